### rtl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Shared sizes, word types and arithmetic constants for the 5x5 box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

   // Frame geometry.
   localparam int MAX_WIDTH   = 1024;
   localparam int LINE_STORES = 4;
   localparam int WIN         = LINE_STORES + 1;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 16;
   localparam int FW_W        = 11;
   localparam int MIN_SIZE    = 5;

   // Window position rules: the window is full from this column and row on,
   // and the centre sits this far behind the incoming pixel.
   localparam int EMIT_START  = WIN - 1;
   localparam int CENTRE_OFS  = WIN / 2;

   // Register reset values.
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // Pixel and sum widths.
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int LINE_W    = LINE_STORES * PIX_W;
   localparam int COLSUM_W  = CH_W + $clog2(WIN);
   localparam int WINSUM_W  = CH_W + $clog2(WIN * WIN);

   // Division by 25 as a multiply by a rounded-up reciprocal. The error of
   // the reciprocal stays below one part in 25 of the largest window sum.
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + WIN * WIN - 1) / (WIN * WIN);
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = WINSUM_W + RECIP_W;

   // Configuration register indexes.
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // Input word: one pixel, first channel in the low bits.
   typedef struct packed {
      logic [CH_W-1:0] chan2;
      logic [CH_W-1:0] chan1;
      logic [CH_W-1:0] chan0;
   } req_word_type;

   // Result word: one blurred centre pixel.
   typedef struct packed {
      logic [COL_W-1:0] centre_col;
      logic [ROW_W-1:0] centre_row;
      logic [CH_W-1:0]  blur0;
      logic [CH_W-1:0]  blur1;
      logic [CH_W-1:0]  blur2;
      logic             frame_end;
   } rsp_word_type;

   // Sum of one window column, per channel.
   typedef struct packed {
      logic [COLSUM_W-1:0] c0;
      logic [COLSUM_W-1:0] c1;
      logic [COLSUM_W-1:0] c2;
   } colsum_type;

   // Running sum along the cell chain, per channel.
   typedef struct packed {
      logic [WINSUM_W-1:0] c0;
      logic [WINSUM_W-1:0] c1;
      logic [WINSUM_W-1:0] c2;
   } winsum_type;

   // Position data that travels with a pixel down the pipeline.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } meta_type;

endpackage

### rtl/bbr_line_mem.sv
// ----------------------------------------------------------------------------
// Box blur line memory
// Holds the last four rows side by side, one word per column, with one
// registered read port and one write port.
// ----------------------------------------------------------------------------
module bbr_line_mem (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [bbr_pkg::COL_W-1:0]   rd_addr,
   output logic [bbr_pkg::LINE_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [bbr_pkg::COL_W-1:0]   wr_addr,
   input  logic [bbr_pkg::LINE_W-1:0]  wr_data
);

   logic [bbr_pkg::LINE_W-1:0] line_mem_ff [bbr_pkg::MAX_WIDTH];
   logic [bbr_pkg::LINE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bbr_cell.sv
// ----------------------------------------------------------------------------
// Box blur window cell
// Holds the channel sums of one window column, hands them to the next cell
// on every pixel, and adds them into the running window sum.
// ----------------------------------------------------------------------------
module bbr_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  bbr_pkg::colsum_type  col_prev,
   output bbr_pkg::colsum_type  col_next,
   input  bbr_pkg::winsum_type  part_prev,
   output bbr_pkg::winsum_type  part_next
);

   bbr_pkg::colsum_type col_ff;

   // Take the neighbor's column when a pixel moves the window.
   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_prev;
      end
   end

   assign col_next = col_ff;

   // Add this column into the sum coming down the chain.
   always_comb begin
      part_next.c0 = part_prev.c0 + bbr_pkg::WINSUM_W'(col_ff.c0);
      part_next.c1 = part_prev.c1 + bbr_pkg::WINSUM_W'(col_ff.c1);
      part_next.c2 = part_prev.c2 + bbr_pkg::WINSUM_W'(col_ff.c2);
   end

endmodule

### rtl/box_blur_5x5_rgb.sv
// ----------------------------------------------------------------------------
// 5x5 box blur, three 8-bit channels
// Blurs a raster pixel stream and emits the interior pixels with their
// coordinates.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while its output buffer is not full:
// the line memory does one read and one write for every pixel, and a row of
// five cells holds the window's column sums. A result passes through the
// stage A, B, C and D registers and the output register. Pixels within two
// of any frame edge produce no result word, so the output carries
// (width-4) x (height-4) words per frame, the last one flagged by frame_end.
// Writing either size register restarts the frame; write only while no
// pixel is in flight. A two-word output buffer parks one word while the
// output stalls, and the input stops while both words are held.
module box_blur_5x5_rgb (
   input  logic                   clock,
   input  logic                   reset,
   // Pixel input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bbr_pkg::req_word_type  req_data,
   // Blurred pixel output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bbr_pkg::rsp_word_type  rsp_data,
   // Register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int WIN      = bbr_pkg::WIN;
   localparam int COL_W    = bbr_pkg::COL_W;
   localparam int ROW_W    = bbr_pkg::ROW_W;
   localparam int FW_W     = bbr_pkg::FW_W;
   localparam int CH_W     = bbr_pkg::CH_W;
   localparam int PIX_W    = bbr_pkg::PIX_W;
   localparam int LINE_W   = bbr_pkg::LINE_W;
   localparam int COLSUM_W = bbr_pkg::COLSUM_W;
   localparam int PROD_W   = bbr_pkg::PROD_W;
   localparam int SHIFT    = bbr_pkg::RECIP_SHIFT;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   logic              cfg_write;
   logic [FW_W-1:0]   frame_width_ff;
   logic [ROW_W-1:0]  frame_height_ff;
   bbr_pkg::reg_index_type cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = bbr_pkg::reg_index_type'(paddr[2]);

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_W'(bbr_pkg::FRAME_WIDTH_RESET);
         frame_height_ff <= ROW_W'(bbr_pkg::FRAME_HEIGHT_RESET);
      end else if (cfg_write) begin
         unique case (cfg_index)
            bbr_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[FW_W-1:0];
            bbr_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      unique case (cfg_index)
         bbr_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_ff);
         bbr_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Effective frame size and raster counters
   // ------------------------------------------------------------------
   logic [COL_W:0]    width_eff;
   logic [ROW_W-1:0]  height_eff;
   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;

   // Clamp the sizes to what the line memory and the window allow.
   always_comb begin
      if (32'(frame_width_ff) < bbr_pkg::MIN_SIZE) begin
         width_eff = (COL_W + 1)'(bbr_pkg::MIN_SIZE);
      end else if (32'(frame_width_ff) > bbr_pkg::MAX_WIDTH) begin
         width_eff = (COL_W + 1)'(bbr_pkg::MAX_WIDTH);
      end else begin
         width_eff = (COL_W + 1)'(frame_width_ff);
      end
      if (32'(frame_height_ff) < bbr_pkg::MIN_SIZE) begin
         height_eff = ROW_W'(bbr_pkg::MIN_SIZE);
      end else begin
         height_eff = frame_height_ff;
      end
      last_col = COL_W'(width_eff - 1'b1);
      last_row = height_eff - 1'b1;
   end

   logic              accept;
   logic              advance;
   logic [COL_W-1:0]  col_count_ff, col_count_in;
   logic [ROW_W-1:0]  row_count_ff, row_count_in;

   // The whole pipeline moves together; it stops only when the output
   // buffer holds two words.
   logic skid_valid_ff;
   assign advance   = !skid_valid_ff;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   // Raster position of the next pixel.
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (cfg_write) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (accept) begin
         if (col_count_ff == last_col) begin
            col_count_in = '0;
            row_count_in = (row_count_ff == last_row) ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: pixel and line memory read
   // ------------------------------------------------------------------
   logic                 a_valid_ff;
   logic                 a_emit_ff;
   logic [COL_W-1:0]     a_addr_ff;
   logic [PIX_W-1:0]     a_pix_ff;
   bbr_pkg::meta_type    a_meta_ff;
   logic [LINE_W-1:0]    line_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_addr_ff           <= col_count_ff;
         a_pix_ff            <= PIX_W'(req_data);
         a_emit_ff           <= (32'(col_count_ff) >= bbr_pkg::EMIT_START) &&
                                (32'(row_count_ff) >= bbr_pkg::EMIT_START);
         a_meta_ff.col       <= col_count_ff - COL_W'(bbr_pkg::CENTRE_OFS);
         a_meta_ff.row       <= row_count_ff - ROW_W'(bbr_pkg::CENTRE_OFS);
         a_meta_ff.frame_end <= (col_count_ff == last_col) && (row_count_ff == last_row);
      end
   end

   // Line memory: read the column on accept, write the cascaded column back
   // as the pixel leaves stage A.
   logic              shift;
   logic [LINE_W-1:0] line_wr;

   assign shift   = advance && a_valid_ff;
   assign line_wr = {line_rd[LINE_W-PIX_W-1:0], a_pix_ff};

   bbr_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (line_rd),
      .wr_en   (shift),
      .wr_addr (a_addr_ff),
      .wr_data (line_wr)
   );

   // Sum of the new window column: four stored rows plus the new pixel.
   bbr_pkg::colsum_type col_sum;

   always_comb begin
      col_sum.c0 = COLSUM_W'(a_pix_ff[0 +: CH_W]);
      col_sum.c1 = COLSUM_W'(a_pix_ff[CH_W +: CH_W]);
      col_sum.c2 = COLSUM_W'(a_pix_ff[2*CH_W +: CH_W]);
      for (int i = 0; i < bbr_pkg::LINE_STORES; i++) begin
         col_sum.c0 = col_sum.c0 + COLSUM_W'(line_rd[i*PIX_W +: CH_W]);
         col_sum.c1 = col_sum.c1 + COLSUM_W'(line_rd[i*PIX_W + CH_W +: CH_W]);
         col_sum.c2 = col_sum.c2 + COLSUM_W'(line_rd[i*PIX_W + 2*CH_W +: CH_W]);
      end
   end

   // ------------------------------------------------------------------
   // Stage B: window cell chain
   // ------------------------------------------------------------------
   bbr_pkg::colsum_type cell_col  [WIN+1];
   bbr_pkg::winsum_type cell_part [WIN+1];

   assign cell_col[0]  = col_sum;
   assign cell_part[0] = '0;

   for (genvar k = 0; k < WIN; k++) begin : g_cell
      bbr_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .col_prev  (cell_col[k]),
         .col_next  (cell_col[k+1]),
         .part_prev (cell_part[k]),
         .part_next (cell_part[k+1])
      );
   end

   logic              b_valid_ff;
   bbr_pkg::meta_type b_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_meta_ff <= a_meta_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: registered window sums
   // ------------------------------------------------------------------
   logic                c_valid_ff;
   bbr_pkg::meta_type   c_meta_ff;
   bbr_pkg::winsum_type c_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_meta_ff <= b_meta_ff;
         c_sum_ff  <= cell_part[WIN];
      end
   end

   // ------------------------------------------------------------------
   // Stage D: divide by 25 through the reciprocal
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]     prod0, prod1, prod2;
   logic                  d_valid_ff;
   bbr_pkg::rsp_word_type d_word_ff;

   assign prod0 = PROD_W'(c_sum_ff.c0) * PROD_W'(bbr_pkg::RECIP);
   assign prod1 = PROD_W'(c_sum_ff.c1) * PROD_W'(bbr_pkg::RECIP);
   assign prod2 = PROD_W'(c_sum_ff.c2) * PROD_W'(bbr_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_word_ff.centre_col <= c_meta_ff.col;
         d_word_ff.centre_row <= c_meta_ff.row;
         d_word_ff.blur0      <= prod0[SHIFT +: CH_W];
         d_word_ff.blur1      <= prod1[SHIFT +: CH_W];
         d_word_ff.blur2      <= prod2[SHIFT +: CH_W];
         d_word_ff.frame_end  <= c_meta_ff.frame_end;
      end
   end

   // ------------------------------------------------------------------
   // Output register with skid word
   // ------------------------------------------------------------------
   logic                  push;
   logic                  rsp_valid_ff;
   bbr_pkg::rsp_word_type rsp_data_ff;
   bbr_pkg::rsp_word_type skid_data_ff;

   assign push = advance && d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_ready) begin
         // Output stalled: park a new word in the skid register.
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_data_ff <= d_word_ff;
         end
      end else if (skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (push) begin
         rsp_data_ff <= d_word_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
